@@ rtl/slc_pkg.sv @@
// slc_pkg: shared constants, codes and types for the set-associative LRU tag tracker.
// No dependencies; used by the interfaces, the tracker, the access unit and the checker.
`default_nettype none

package slc_pkg;

    localparam int ADDR_FIELD_W = 32;
    localparam int COUNT_W      = 32;
    localparam int RANK_W       = 3;
    localparam int CMD_W        = 2;
    localparam int OUTCOME_W    = 2;
    localparam int HITS_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_CFG_W   = 4;

    localparam logic [RANK_W-1:0]  RANK_MAX  = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
    localparam logic [WAYS_CFG_W-1:0]   WAYS_RST       = 4'd1;

    typedef logic [RANK_W-1:0] t_rank;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_MISS  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SECOND
    } t_state;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v, input logic en);
        sat_inc = (en && v != COUNT_MAX) ? v + COUNT_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/slc_in_if.sv @@
// slc_in_if: input channel carrying one access item (command and address).
// Depends on slc_pkg for field widths.
`default_nettype none

interface slc_in_if;
    logic                              valid;
    logic                              ready;
    logic [slc_pkg::CMD_W-1:0]         command;
    logic [slc_pkg::ADDR_FIELD_W-1:0]  address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
    modport mon    (input valid, input ready, input command, input address);
endinterface

`default_nettype wire

@@ rtl/slc_out_if.sv @@
// slc_out_if: result channel carrying per-item outcome and running totals.
// Depends on slc_pkg for field widths.
`default_nettype none

interface slc_out_if;
    logic                           valid;
    logic                           ready;
    logic [slc_pkg::OUTCOME_W-1:0]  first_outcome;
    logic [slc_pkg::HITS_W-1:0]     hits_this_item;
    logic [slc_pkg::COUNT_W-1:0]    hit_total;
    logic [slc_pkg::COUNT_W-1:0]    miss_total;
    logic [slc_pkg::COUNT_W-1:0]    eviction_total;

    modport source (output valid, output first_outcome, output hits_this_item,
                    output hit_total, output miss_total, output eviction_total,
                    input ready);
    modport sink   (input valid, input first_outcome, input hits_this_item,
                    input hit_total, input miss_total, input eviction_total,
                    output ready);
    modport mon    (input valid, input ready, input first_outcome, input hits_this_item,
                    input hit_total, input miss_total, input eviction_total);
endinterface

`default_nettype wire

@@ rtl/slc_access.sv @@
// slc_access: one cache access on a whole set row - hit detect, fill, LRU victim, rank update.
// Combinational; depends on slc_pkg.
`default_nettype none

module slc_access #(
    parameter int WAYS  = 8,
    parameter int TAG_W = 32
) (
    input  logic [WAYS*(1+TAG_W+slc_pkg::RANK_W)-1:0] i_row,
    input  logic [TAG_W-1:0]                          i_tag,
    input  logic [WAYS-1:0]                           i_used,
    output logic [WAYS*(1+TAG_W+slc_pkg::RANK_W)-1:0] o_row,
    output slc_pkg::t_outcome                         o_outcome
);

    localparam int WIDX   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_N = 1 << slc_pkg::RANK_W;

    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag;
        slc_pkg::t_rank       rank;
    } t_line;

    t_line [WAYS-1:0] row_in;
    t_line [WAYS-1:0] row_out;

    logic [WAYS-1:0]           hit_vec;
    logic [WAYS-1:0]           free_vec;
    logic [WAYS-1:0]           oldest_vec;
    slc_pkg::t_rank            max_rank;
    logic [WIDX-1:0]           way_sel;
    logic [slc_pkg::RANK_W:0]  old_rank;

    assign row_in = i_row;
    assign o_row  = row_out;

    // lowest-numbered set bit
    function automatic logic [WIDX-1:0] low_idx(input logic [WAYS-1:0] v);
        logic [WIDX-1:0] idx;
        idx = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = WIDX'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        max_rank = '0;
        for (int i = 0; i < WAYS; i++) begin
            hit_vec[i]  = i_used[i] && row_in[i].valid && (row_in[i].tag == i_tag);
            free_vec[i] = i_used[i] && !row_in[i].valid;
        end
        for (int r = 1; r < RANK_N; r++) begin
            for (int i = 0; i < WAYS; i++) begin
                if (i_used[i] && (int'(row_in[i].rank) >= r)) begin
                    max_rank = slc_pkg::RANK_W'(r);
                end
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            oldest_vec[i] = i_used[i] && (row_in[i].rank == max_rank);
        end

        if (|hit_vec) begin
            way_sel   = low_idx(hit_vec);
            old_rank  = {1'b0, row_in[way_sel].rank};
            o_outcome = slc_pkg::OUT_HIT;
        end else if (|free_vec) begin
            way_sel   = low_idx(free_vec);
            // an empty line ages every valid in-use line of the set that is below the maximum rank
            old_rank  = {1'b0, slc_pkg::RANK_MAX} + (slc_pkg::RANK_W+1)'(1);
            o_outcome = slc_pkg::OUT_MISS;
        end else begin
            way_sel   = low_idx(oldest_vec);
            old_rank  = {1'b0, max_rank};
            o_outcome = slc_pkg::OUT_EVICT;
        end

        row_out = row_in;
        for (int i = 0; i < WAYS; i++) begin
            if ((WIDX'(i) != way_sel) && i_used[i] && row_in[i].valid &&
                ({1'b0, row_in[i].rank} < old_rank) &&
                (row_in[i].rank != slc_pkg::RANK_MAX)) begin
                row_out[i].rank = row_in[i].rank + slc_pkg::RANK_W'(1);
            end
        end
        row_out[way_sel].valid = 1'b1;
        row_out[way_sel].tag   = i_tag;
        row_out[way_sel].rank  = '0;
    end

endmodule

`default_nettype wire

@@ rtl/set_assoc_lru_cache_tracker.sv @@
// Set-associative LRU tag tracker: one row of the set memory per set, read, updated, written back.
// Items are accepted only while idle; the set row is read on acceptance, then the access unit runs
// once for a load or store and twice for a modify; the row is written back as the result is registered.
// A held result register stalls the last access, and no new item is taken until the current one ends.
// Reset (synchronous, active low) clears counters, state, config registers and per-set
// valid flags at once; no clearing pass over the memory is needed.
`default_nettype none

module set_assoc_lru_cache_tracker #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    slc_in_if.sink                            i_in,
    slc_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW       = slc_pkg::ADDR_FIELD_W;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int TAG_W    = (ADDR_WIDTH < AW) ? ADDR_WIDTH : AW;
    localparam int LINE_W   = 1 + TAG_W + slc_pkg::RANK_W;
    localparam int ROW_W    = WAYS * LINE_W;
    localparam int SHIFT_W  = $clog2((1 << slc_pkg::BLOCK_BITS_W) + MAX_SET_BITS + 1);
    localparam logic [AW-1:0] ADDR_MASK =
        (ADDR_WIDTH >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_WIDTH) - 64'd1);

    // configuration
    logic [slc_pkg::SET_BITS_W-1:0]   r_set_bits;
    logic [slc_pkg::BLOCK_BITS_W-1:0] r_block_bits;
    logic [slc_pkg::WAYS_CFG_W-1:0]   r_ways_cfg;

    // control
    slc_pkg::t_state             r_state, n_state;
    logic [NUM_SETS-1:0]         r_row_init;
    logic                        r_q_init;
    logic [slc_pkg::COUNT_W-1:0] r_hits, r_misses, r_evicts;
    logic [slc_pkg::COUNT_W-1:0] n_hits, n_misses, n_evicts;
    logic                        r_out_valid;

    // payload
    logic [SET_W-1:0]             r_set;
    logic [TAG_W-1:0]             r_tag;
    logic                         r_modify;
    logic [ROW_W-1:0]             r_mem_q;
    logic [ROW_W-1:0]             r_row;
    slc_pkg::t_outcome            r_first;
    logic [slc_pkg::HITS_W-1:0]   r_hits_item, n_hits_item;
    slc_pkg::t_outcome            r_out_first;
    logic [slc_pkg::HITS_W-1:0]   r_out_hits;
    logic [slc_pkg::COUNT_W-1:0]  r_out_hit_total, r_out_miss_total, r_out_evict_total;

    logic [ROW_W-1:0] mem [NUM_SETS];

    logic                in_acc;
    logic [SHIFT_W-1:0]  sb_eff;
    logic [AW-1:0]       addr_m;
    logic [AW-1:0]       addr_shr;
    logic [AW-1:0]       tag_full;
    logic [SET_W-1:0]    set_idx;
    logic [WAYS-1:0]     used;
    int                  ways_n;
    logic                out_free;
    logic                step;
    logic                finish;
    logic [ROW_W-1:0]    row_src;
    logic [ROW_W-1:0]    row_new;
    slc_pkg::t_outcome   outcome;
    logic                is_hit;

    assign in_acc = i_in.valid && i_in.ready;

    // set and tag split
    always_comb begin
        if (int'(r_set_bits) > MAX_SET_BITS) begin
            sb_eff = SHIFT_W'(MAX_SET_BITS);
        end else begin
            sb_eff = SHIFT_W'(r_set_bits);
        end
        addr_m   = i_in.address & ADDR_MASK;
        addr_shr = addr_m >> r_block_bits;
        set_idx  = SET_W'(addr_shr & ~({AW{1'b1}} << sb_eff));
        tag_full = addr_m >> (SHIFT_W'(r_block_bits) + sb_eff);
    end

    always_comb begin
        if (r_ways_cfg == '0) begin
            ways_n = 1;
        end else if (int'(r_ways_cfg) > WAYS) begin
            ways_n = WAYS;
        end else begin
            ways_n = int'(r_ways_cfg);
        end
        for (int i = 0; i < WAYS; i++) begin
            used[i] = (i < ways_n);
        end
    end

    // a never-written set reads as all lines invalid
    assign row_src = (r_state == slc_pkg::ST_SECOND) ? r_row :
                     (r_q_init ? r_mem_q : '0);

    slc_access #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_slc_access (
        .i_row     (row_src),
        .i_tag     (r_tag),
        .i_used    (used),
        .o_row     (row_new),
        .o_outcome (outcome)
    );

    assign is_hit = (outcome == slc_pkg::OUT_HIT);

    always_comb begin
        n_state     = r_state;
        out_free    = !r_out_valid || o_out.ready;
        step        = 1'b0;
        finish      = 1'b0;
        n_hits_item = r_hits_item;
        case (r_state)
            slc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = slc_pkg::ST_LOOK;
                end
            end
            slc_pkg::ST_LOOK: begin
                n_hits_item = {1'b0, is_hit};
                if (r_modify) begin
                    step    = 1'b1;
                    n_state = slc_pkg::ST_SECOND;
                end else if (out_free) begin
                    step    = 1'b1;
                    finish  = 1'b1;
                    n_state = slc_pkg::ST_IDLE;
                end
            end
            slc_pkg::ST_SECOND: begin
                n_hits_item = r_hits_item + slc_pkg::HITS_W'(is_hit);
                if (out_free) begin
                    step    = 1'b1;
                    finish  = 1'b1;
                    n_state = slc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slc_pkg::ST_IDLE;
            end
        endcase
        n_hits   = slc_pkg::sat_inc(r_hits, step && is_hit);
        n_misses = slc_pkg::sat_inc(r_misses, step && !is_hit);
        n_evicts = slc_pkg::sat_inc(r_evicts, step && (outcome == slc_pkg::OUT_EVICT));
    end

    assign i_in.ready = i_rst_n && (r_state == slc_pkg::ST_IDLE);

    // set memory: written back on the last access of an item, read on acceptance
    always_ff @(posedge i_clk) begin
        if (finish) begin
            mem[r_set] <= row_new;
        end
        if (in_acc) begin
            r_mem_q <= mem[set_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= slc_pkg::ST_IDLE;
            r_row_init   <= '0;
            r_q_init     <= 1'b0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_evicts     <= '0;
            r_out_valid  <= 1'b0;
            r_set_bits   <= slc_pkg::SET_BITS_RST;
            r_block_bits <= slc_pkg::BLOCK_BITS_RST;
            r_ways_cfg   <= slc_pkg::WAYS_RST;
        end else begin
            r_state  <= n_state;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_evicts <= n_evicts;
            if (in_acc) begin
                r_q_init <= r_row_init[set_idx];
            end
            if (finish) begin
                r_row_init[r_set] <= 1'b1;
                r_out_valid       <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    slc_pkg::CFG_SET_BITS:    r_set_bits   <= i_cfg_data[slc_pkg::SET_BITS_W-1:0];
                    slc_pkg::CFG_BLOCK_BITS:  r_block_bits <= i_cfg_data;
                    slc_pkg::CFG_WAYS_IN_USE: r_ways_cfg   <= i_cfg_data[slc_pkg::WAYS_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set    <= set_idx;
            r_tag    <= TAG_W'(tag_full);
            r_modify <= (i_in.command == slc_pkg::CMD_MODIFY);
        end
        if (r_state == slc_pkg::ST_LOOK && step) begin
            r_first <= outcome;
        end
        if (step) begin
            r_row       <= row_new;
            r_hits_item <= n_hits_item;
        end
        if (finish) begin
            r_out_first       <= (r_state == slc_pkg::ST_LOOK) ? outcome : r_first;
            r_out_hits        <= n_hits_item;
            r_out_hit_total   <= n_hits;
            r_out_miss_total  <= n_misses;
            r_out_evict_total <= n_evicts;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.first_outcome  = r_out_first;
    assign o_out.hits_this_item = r_out_hits;
    assign o_out.hit_total      = r_out_hit_total;
    assign o_out.miss_total     = r_out_miss_total;
    assign o_out.eviction_total = r_out_evict_total;

endmodule

`default_nettype wire

@@ rtl/slc_checker.sv @@
// slc_checker: port-level assertions for the tag tracker, attached by bind.
// Depends on slc_pkg; watches the handshake of both channels of the top level and the result payload.
`default_nettype none

module slc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [slc_pkg::OUTCOME_W-1:0] i_first_outcome,
    input logic [slc_pkg::HITS_W-1:0]    i_hits_this_item,
    input logic [slc_pkg::COUNT_W-1:0]   i_hit_total,
    input logic [slc_pkg::COUNT_W-1:0]   i_miss_total,
    input logic [slc_pkg::COUNT_W-1:0]   i_eviction_total
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // a newly raised result follows an accepted item, by the load or store path or the longer modify path
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> ($past(in_acc, 2) || $past(in_acc, 3)))
        else $error("result appeared without a matching item");

    // a first-access hit always counts in the item's hit count
    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_first_outcome == slc_pkg::OUT_HIT) |->
            (i_hits_this_item != 2'd0))
        else $error("first access hit but hit count is zero");

    // totals never go backwards from one item to the next
    a_totals_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc ##1 i_out_valid) |->
            (i_hit_total >= $past(i_hit_total) &&
             i_miss_total >= $past(i_miss_total) &&
             i_eviction_total >= $past(i_eviction_total)))
        else $error("running total decreased");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_hit_total) && $stable(i_miss_total) &&
             $stable(i_eviction_total) && $stable(i_first_outcome) &&
             $stable(i_hits_this_item)))
        else $error("stalled result changed");

endmodule

bind set_assoc_lru_cache_tracker slc_checker u_slc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_first_outcome  (o_out.first_outcome),
    .i_hits_this_item (o_out.hits_this_item),
    .i_hit_total      (o_out.hit_total),
    .i_miss_total     (o_out.miss_total),
    .i_eviction_total (o_out.eviction_total)
);

`default_nettype wire

@@ sim/set_assoc_lru_cache_tracker_test.sv @@
`timescale 1ns / 1ps
// set_assoc_lru_cache_tracker_test: self-checking bench for the set-associative LRU tag tracker.
// Needs slc_pkg, slc_in_if, slc_out_if and set_assoc_lru_cache_tracker; keeps its own copy of
// the valid, tag and recency state and predicts the result of every accepted item.

module set_assoc_lru_cache_tracker_test;

    localparam int SET_LOG_MAX = 6;
    localparam int WAY_COUNT   = 8;
    localparam int LINE_COUNT  = (1 << SET_LOG_MAX) * WAY_COUNT;

    localparam logic [slc_pkg::CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [slc_pkg::CMD_W-1:0] CMD_STORE = 2'd1;
    localparam logic [slc_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        slc_pkg::t_outcome                first_outcome;
        logic [slc_pkg::HITS_W-1:0]       hits_this_item;
        logic [slc_pkg::COUNT_W-1:0]      hit_total;
        logic [slc_pkg::COUNT_W-1:0]      miss_total;
        logic [slc_pkg::COUNT_W-1:0]      eviction_total;
    } t_access_report;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [slc_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [slc_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    slc_in_if  in_ch ();
    slc_out_if out_ch ();

    set_assoc_lru_cache_tracker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted tag store and register mirror
    logic                             line_live [LINE_COUNT];
    logic [slc_pkg::ADDR_FIELD_W-1:0] line_key  [LINE_COUNT];
    slc_pkg::t_rank                   line_age  [LINE_COUNT];
    logic [slc_pkg::COUNT_W-1:0]      hit_count;
    logic [slc_pkg::COUNT_W-1:0]      miss_count;
    logic [slc_pkg::COUNT_W-1:0]      evict_count;
    logic [slc_pkg::SET_BITS_W-1:0]   cfg_set_bits;
    logic [slc_pkg::BLOCK_BITS_W-1:0] cfg_block_bits;
    logic [slc_pkg::WAYS_CFG_W-1:0]   cfg_ways;

    t_access_report pending_reports [$];
    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  settings_used  = 0;
    bit  quiet          = 1'b0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [slc_pkg::COUNT_W-1:0] count_up(
        input logic [slc_pkg::COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < LINE_COUNT; i++) begin
            line_live[i] = 1'b0;
            line_key[i]  = '0;
            line_age[i]  = '0;
        end
        hit_count      = '0;
        miss_count     = '0;
        evict_count    = '0;
        cfg_set_bits   = slc_pkg::SET_BITS_RST;
        cfg_block_bits = slc_pkg::BLOCK_BITS_RST;
        cfg_ways       = slc_pkg::WAYS_RST;
    endfunction

    // Make way w most recent; lines younger than its old rank age by one.
    function automatic void promote(input int base, input int ways, input int w,
                                    input int old_rank);
        for (int i = 0; i < ways; i++) begin
            if (i != w && line_live[base + i] && line_age[base + i] < old_rank &&
                line_age[base + i] < slc_pkg::RANK_MAX)
                line_age[base + i] = line_age[base + i] + 1'b1;
        end
        line_age[base + w] = '0;
    endfunction

    function automatic slc_pkg::t_outcome lookup_once(
        input logic [slc_pkg::ADDR_FIELD_W-1:0] addr);
        int sb;
        int ways;
        int base;
        int victim;
        int top;
        logic [slc_pkg::ADDR_FIELD_W-1:0] set_idx;
        logic [slc_pkg::ADDR_FIELD_W-1:0] key;
        sb      = (cfg_set_bits > SET_LOG_MAX) ? SET_LOG_MAX : int'(cfg_set_bits);
        ways    = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_COUNT) ? WAY_COUNT : int'(cfg_ways));
        set_idx = (addr >> cfg_block_bits) & ((32'd1 << sb) - 32'd1);
        key     = addr >> (int'(cfg_block_bits) + sb);
        base    = int'(set_idx) * WAY_COUNT;
        for (int i = 0; i < ways; i++) begin
            if (line_live[base + i] && line_key[base + i] == key) begin
                promote(base, ways, i, line_age[base + i]);
                hit_count = count_up(hit_count);
                return slc_pkg::OUT_HIT;
            end
        end
        miss_count = count_up(miss_count);
        for (int i = 0; i < ways; i++) begin
            if (!line_live[base + i]) begin
                line_live[base + i] = 1'b1;
                line_key[base + i]  = key;
                promote(base, ways, i, slc_pkg::RANK_MAX + 1);
                return slc_pkg::OUT_MISS;
            end
        end
        // Oldest used way goes; the lowest index wins a tie.
        victim = 0;
        top    = line_age[base];
        for (int i = 1; i < ways; i++) begin
            if (line_age[base + i] > top) begin
                top    = line_age[base + i];
                victim = i;
            end
        end
        line_key[base + victim] = key;
        promote(base, ways, victim, top);
        evict_count = count_up(evict_count);
        return slc_pkg::OUT_EVICT;
    endfunction

    function automatic t_access_report predict_item(
        input logic [slc_pkg::CMD_W-1:0] cmd,
        input logic [slc_pkg::ADDR_FIELD_W-1:0] addr);
        t_access_report r;
        r.first_outcome  = lookup_once(addr);
        r.hits_this_item = (r.first_outcome == slc_pkg::OUT_HIT) ? 2'd1 : 2'd0;
        if (cmd == slc_pkg::CMD_MODIFY) begin
            if (lookup_once(addr) == slc_pkg::OUT_HIT)
                r.hits_this_item = r.hits_this_item + 1'b1;
        end
        r.hit_total      = hit_count;
        r.miss_total     = miss_count;
        r.eviction_total = evict_count;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Leaves the caller at a falling edge with valid still high.
    task automatic send_item(input logic [slc_pkg::CMD_W-1:0] cmd,
                             input logic [slc_pkg::ADDR_FIELD_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.address <= addr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_reports.push_back(predict_item(cmd, addr));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_until_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic configure(input logic [slc_pkg::SET_BITS_W-1:0] sb,
                             input logic [slc_pkg::BLOCK_BITS_W-1:0] bb,
                             input logic [slc_pkg::WAYS_CFG_W-1:0] ways);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= slc_pkg::CFG_SET_BITS;
        i_cfg_data  <= slc_pkg::CFG_DATA_W'(sb);
        @(negedge i_clk);
        i_cfg_index <= slc_pkg::CFG_BLOCK_BITS;
        i_cfg_data  <= slc_pkg::CFG_DATA_W'(bb);
        @(negedge i_clk);
        i_cfg_index <= slc_pkg::CFG_WAYS_IN_USE;
        i_cfg_data  <= slc_pkg::CFG_DATA_W'(ways);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_set_bits   = sb;
        cfg_block_bits = bb;
        cfg_ways       = ways;
        settings_used++;
    endtask

    task automatic compare_field(input string name, input logic [slc_pkg::COUNT_W-1:0] want,
                                 input logic [slc_pkg::COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic test_basic_commands();
        send_item(CMD_LOAD, 32'h0000_0000);
        send_item(CMD_STORE, 32'h0000_000f);
        send_item(slc_pkg::CMD_MODIFY, 32'h0000_0100);
        send_item(CMD_SPARE, 32'hffff_ffff);
        send_item(CMD_LOAD, 32'hffff_ffff);
        send_item(slc_pkg::CMD_MODIFY, 32'hffff_fff0);
    endtask

    task automatic test_register_extremes();
        // Set bits clamp to the maximum, zero ways acts as one.
        configure(3'd7, 5'd0, 4'd0);
        send_item(slc_pkg::CMD_MODIFY, 32'h0000_003f);
        send_item(CMD_LOAD, 32'h0000_007f);
        // One set, way count clamps to the full width; the ninth fill evicts.
        configure(3'd0, 5'd0, 4'd15);
        for (int i = 0; i < 9; i++)
            send_item(CMD_LOAD, 32'(i));
        send_item(CMD_STORE, 32'd2);
        send_item(CMD_LOAD, 32'd5);
        // Narrow the set: ranks left from the wider setting pick the victim.
        configure(3'd0, 5'd0, 4'd3);
        send_item(CMD_LOAD, 32'h0000_0100);
        send_item(slc_pkg::CMD_MODIFY, 32'h0000_0200);
        configure(3'd6, 5'd26, 4'd8);
        send_item(CMD_LOAD, 32'hffff_ffff);
        send_item(slc_pkg::CMD_MODIFY, 32'hfc00_0000);
        configure(3'd2, 5'd31, 4'd1);
        send_item(CMD_LOAD, 32'h8000_0000);
    endtask

    task automatic test_random_traffic();
        logic [slc_pkg::ADDR_FIELD_W-1:0] hot [$];
        logic [slc_pkg::ADDR_FIELD_W-1:0] set_field;
        logic [slc_pkg::ADDR_FIELD_W-1:0] offset_mask;
        logic [slc_pkg::ADDR_FIELD_W-1:0] shared;
        logic [slc_pkg::ADDR_FIELD_W-1:0] addr;
        logic [slc_pkg::CMD_W-1:0]        cmd;
        int sb;
        int roll;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin
                    configure(3'd0, 5'd2, 4'd8);
                end
                1: begin
                    configure(3'd1, 5'd0, 4'd4);
                end
                2: begin
                    configure(3'd6, 5'd26, 4'd2);
                end
                default: begin
                    configure(slc_pkg::SET_BITS_W'($urandom_range(0, 7)),
                              slc_pkg::BLOCK_BITS_W'(($urandom_range(0, 3) == 0) ?
                                  $urandom_range(0, 31) : $urandom_range(0, 8)),
                              slc_pkg::WAYS_CFG_W'($urandom_range(0, 15)));
                end
            endcase
            quiet       = (phase % 4 == 3);
            sb          = (cfg_set_bits > SET_LOG_MAX) ? SET_LOG_MAX : int'(cfg_set_bits);
            offset_mask = (32'd1 << cfg_block_bits) - 32'd1;
            set_field   = ((32'd1 << sb) - 32'd1) << cfg_block_bits;
            shared      = $urandom;
            // Build a working set; each address has an even chance of crowding into one shared set to force evictions.
            hot.delete();
            repeat ($urandom_range(3, 20)) begin
                addr = $urandom;
                if ($urandom_range(0, 1) == 1)
                    addr = (addr & ~set_field) | (shared & set_field);
                hot.push_back(addr);
            end
            for (int n = 0; n < 83; n++) begin
                roll = $urandom_range(0, 9);
                cmd  = (roll < 3) ? CMD_LOAD : (roll < 6) ? CMD_STORE :
                       (roll < 9) ? slc_pkg::CMD_MODIFY : CMD_SPARE;
                if ($urandom_range(0, 4) == 0)
                    addr = $urandom;
                else
                    addr = (hot[$urandom_range(0, hot.size() - 1)] & ~offset_mask) |
                           ($urandom & offset_mask);
                // Hold the sender until the pipe is empty now and then.
                if (n == 41 && phase % 2 == 1)
                    wait_until_drained();
                send_item(cmd, addr);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin : result_ready
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (quiet) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 2) != 0);
                hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_access_report want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_reports.size() == 0) begin
                $error("result arrived with no item outstanding");
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                results_seen++;
                compare_field("first_outcome", want.first_outcome, out_ch.first_outcome);
                compare_field("hits_this_item", want.hits_this_item, out_ch.hits_this_item);
                compare_field("hit_total", want.hit_total, out_ch.hit_total);
                compare_field("miss_total", want.miss_total, out_ch.miss_total);
                compare_field("eviction_total", want.eviction_total, out_ch.eviction_total);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = slc_pkg::CFG_SET_BITS;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.address = '0;
        clear_model();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_basic_commands();
        test_register_extremes();
        test_random_traffic();
        wait_until_drained();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d items under %0d register settings, %0d results checked.",
                 items_sent, settings_used, results_seen);
        $display("Predicted totals: %0d hits, %0d misses, %0d evictions.",
                 hit_count, miss_count, evict_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/slc_pkg.sv
rtl/slc_in_if.sv
rtl/slc_out_if.sv
rtl/slc_access.sv
rtl/set_assoc_lru_cache_tracker.sv
rtl/slc_checker.sv
sim/set_assoc_lru_cache_tracker_test.sv
